[rtl/assert_macros.svh]
// assertion macros used by the top level
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// condition on the same edge
`define TNEGO_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// condition on the following edge
`define TNEGO_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/tnego_pkg.sv]
// types, byte codes and reply tables of the telnet option negotiator
`default_nettype none

package tnego_pkg;

  localparam logic [7:0] B_IAC  = 8'd255;
  localparam logic [7:0] B_DONT = 8'd254;
  localparam logic [7:0] B_DO   = 8'd253;
  localparam logic [7:0] B_WONT = 8'd252;
  localparam logic [7:0] B_WILL = 8'd251;
  localparam logic [7:0] B_SB   = 8'd250;
  localparam logic [7:0] B_SE   = 8'd240;
  localparam logic [7:0] B_CR   = 8'd13;

  localparam logic [7:0] OPT_BIN    = 8'd0;
  localparam logic [7:0] OPT_ECHO   = 8'd1;
  localparam logic [7:0] OPT_SGA    = 8'd3;
  localparam logic [7:0] OPT_TTYPE  = 8'd24;
  localparam logic [7:0] OPT_NAWS   = 8'd31;
  localparam logic [7:0] OPT_ENV    = 8'd36;
  localparam logic [7:0] OPT_NEWENV = 8'd39;
  localparam logic [7:0] SUB_SEND   = 8'd1;

  localparam logic [7:0] NAWS_COLS = 8'd80;
  localparam logic [7:0] NAWS_ROWS = 8'd25;

  typedef enum logic [2:0] {
    PS_DATA,
    PS_IAC,
    PS_CMD,
    PS_SBOPT,
    PS_SBDATA,
    PS_SBIAC
  } ps_e;

  // reply segments: a burst is one segment or [caps,] command[, tail]
  typedef enum logic [2:0] {
    SEG_NONE,
    SEG_DATA,
    SEG_CAPS,
    SEG_CMD,
    SEG_NAWS,
    SEG_ENV,
    SEG_TTYPE
  } seg_e;

  typedef struct packed {
    seg_e       first;
    seg_e       tail;
    logic [7:0] verb;
    logic [7:0] opt;
  } desc_t;

  function automatic logic [5:0] seg_len(input seg_e seg);
    logic [5:0] n;
    case (seg)
      SEG_DATA:  n = 6'd1;
      SEG_CAPS:  n = 6'd12;
      SEG_CMD:   n = 6'd3;
      SEG_NAWS:  n = 6'd9;
      SEG_ENV:   n = 6'd37;
      SEG_TTYPE: n = 6'd11;
      default:   n = 6'd1;
    endcase
    return n;
  endfunction

  function automatic logic [7:0] caps_byte(input logic [5:0] idx);
    logic [7:0] b;
    case (idx)
      6'd0, 6'd3, 6'd6, 6'd9:  b = B_IAC;
      6'd1, 6'd4, 6'd7, 6'd10: b = B_WILL;
      6'd2:    b = OPT_TTYPE;
      6'd5:    b = OPT_NAWS;
      6'd8:    b = OPT_ENV;
      6'd11:   b = OPT_NEWENV;
      default: b = 8'd0;
    endcase
    return b;
  endfunction

  function automatic logic [7:0] naws_byte(input logic [5:0] idx);
    logic [7:0] b;
    case (idx)
      6'd0:    b = B_IAC;
      6'd1:    b = B_SB;
      6'd2:    b = OPT_NAWS;
      6'd4:    b = NAWS_COLS;
      6'd6:    b = NAWS_ROWS;
      6'd7:    b = B_IAC;
      6'd8:    b = B_SE;
      default: b = 8'd0;
    endcase
    return b;
  endfunction

  function automatic logic [7:0] ttype_byte(input logic [5:0] idx);
    logic [7:0] b;
    case (idx)
      6'd0:    b = B_IAC;
      6'd1:    b = B_SB;
      6'd2:    b = OPT_TTYPE;
      6'd4:    b = "v";
      6'd5:    b = "t";
      6'd6:    b = "1";
      6'd7:    b = "0";
      6'd8:    b = "0";
      6'd9:    b = B_IAC;
      6'd10:   b = B_SE;
      default: b = 8'd0;
    endcase
    return b;
  endfunction

  // environment text, option byte spliced in at index 2
  function automatic logic [7:0] env_byte(input logic [5:0] idx, input logic [7:0] opt);
    logic [7:0] b;
    case (idx)
      6'd0:    b = B_IAC;
      6'd1:    b = B_SB;
      6'd2:    b = opt;
      6'd5:    b = "T";
      6'd6:    b = "E";
      6'd7:    b = "R";
      6'd8:    b = "M";
      6'd9:    b = 8'd1;
      6'd10:   b = "v";
      6'd11:   b = "t";
      6'd12:   b = "1";
      6'd13:   b = "0";
      6'd14:   b = "0";
      6'd16:   b = "C";
      6'd17:   b = "O";
      6'd18:   b = "L";
      6'd19:   b = "U";
      6'd20:   b = "M";
      6'd21:   b = "N";
      6'd22:   b = "S";
      6'd23:   b = 8'd1;
      6'd24:   b = "8";
      6'd25:   b = "0";
      6'd27:   b = "L";
      6'd28:   b = "I";
      6'd29:   b = "N";
      6'd30:   b = "E";
      6'd31:   b = "S";
      6'd32:   b = 8'd1;
      6'd33:   b = "2";
      6'd34:   b = "5";
      6'd35:   b = B_IAC;
      6'd36:   b = B_SE;
      default: b = 8'd0;
    endcase
    return b;
  endfunction

  function automatic logic [7:0] seg_byte(input seg_e seg, input logic [5:0] idx,
                                          input logic [7:0] verb, input logic [7:0] opt);
    logic [7:0] b;
    case (seg)
      SEG_DATA:  b = opt;
      SEG_CAPS:  b = caps_byte(idx);
      SEG_CMD: begin
        case (idx)
          6'd0:    b = B_IAC;
          6'd1:    b = verb;
          default: b = opt;
        endcase
      end
      SEG_NAWS:  b = naws_byte(idx);
      SEG_ENV:   b = env_byte(idx, opt);
      SEG_TTYPE: b = ttype_byte(idx);
      default:   b = 8'd0;
    endcase
    return b;
  endfunction

endpackage

`default_nettype wire

[rtl/tnego_parser.sv]
// telnet byte parser: state registers and reply descriptor per byte
`default_nettype none

module tnego_parser (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             accept_i,
  input  wire logic [7:0]       rx_byte_i,
  output tnego_pkg::desc_t      desc_o,
  output tnego_pkg::ps_e        state_o
);

  tnego_pkg::ps_e state_q, state_d;
  logic [7:0] held_verb_q, held_verb_d;
  logic [7:0] sub_option_q, sub_option_d;
  logic [7:0] sub_first_q, sub_first_d;
  logic       sub_has_q, sub_has_d;
  logic       caps_q, caps_d;

  logic remote_ok, local_ok;

  assign remote_ok = (rx_byte_i == tnego_pkg::OPT_ECHO) || (rx_byte_i == tnego_pkg::OPT_SGA) ||
                     (rx_byte_i == tnego_pkg::OPT_BIN);
  assign local_ok  = (rx_byte_i == tnego_pkg::OPT_SGA) || (rx_byte_i == tnego_pkg::OPT_TTYPE) ||
                     (rx_byte_i == tnego_pkg::OPT_NAWS) || (rx_byte_i == tnego_pkg::OPT_ENV) ||
                     (rx_byte_i == tnego_pkg::OPT_NEWENV) || (rx_byte_i == tnego_pkg::OPT_BIN);

  always_comb begin
    state_d      = state_q;
    held_verb_d  = held_verb_q;
    sub_option_d = sub_option_q;
    sub_first_d  = sub_first_q;
    sub_has_d    = sub_has_q;
    caps_d       = caps_q;
    desc_o.first = tnego_pkg::SEG_NONE;
    desc_o.tail  = tnego_pkg::SEG_NONE;
    desc_o.verb  = held_verb_q;
    desc_o.opt   = rx_byte_i;
    // carriage return is dropped before parsing
    if (rx_byte_i != tnego_pkg::B_CR) begin
      case (state_q)
        tnego_pkg::PS_DATA: begin
          if (rx_byte_i == tnego_pkg::B_IAC) begin
            state_d = tnego_pkg::PS_IAC;
          end else begin
            desc_o.first = tnego_pkg::SEG_DATA;
          end
        end
        tnego_pkg::PS_IAC: begin
          if (rx_byte_i == tnego_pkg::B_IAC) begin
            state_d      = tnego_pkg::PS_DATA;
            desc_o.first = tnego_pkg::SEG_DATA;
          end else if (rx_byte_i == tnego_pkg::B_SB) begin
            state_d = tnego_pkg::PS_SBOPT;
          end else if (rx_byte_i == tnego_pkg::B_SE) begin
            state_d = tnego_pkg::PS_DATA;
          end else begin
            held_verb_d = rx_byte_i;
            state_d     = tnego_pkg::PS_CMD;
          end
        end
        tnego_pkg::PS_CMD: begin
          state_d = tnego_pkg::PS_DATA;
          if ((held_verb_q == tnego_pkg::B_WILL) || (held_verb_q == tnego_pkg::B_DO)) begin
            caps_d       = 1'b1;
            desc_o.first = caps_q ? tnego_pkg::SEG_CMD : tnego_pkg::SEG_CAPS;
            if (held_verb_q == tnego_pkg::B_WILL) begin
              desc_o.verb = remote_ok ? tnego_pkg::B_DO : tnego_pkg::B_DONT;
            end else if (local_ok) begin
              desc_o.verb = tnego_pkg::B_WILL;
              if (rx_byte_i == tnego_pkg::OPT_NAWS) begin
                desc_o.tail = tnego_pkg::SEG_NAWS;
              end else if ((rx_byte_i == tnego_pkg::OPT_ENV) ||
                           (rx_byte_i == tnego_pkg::OPT_NEWENV)) begin
                desc_o.tail = tnego_pkg::SEG_ENV;
              end
            end else begin
              desc_o.verb = tnego_pkg::B_WONT;
            end
          end
        end
        tnego_pkg::PS_SBOPT: begin
          sub_option_d = rx_byte_i;
          sub_has_d    = 1'b0;
          sub_first_d  = 8'd0;
          state_d      = tnego_pkg::PS_SBDATA;
        end
        tnego_pkg::PS_SBDATA: begin
          if (rx_byte_i == tnego_pkg::B_IAC) begin
            state_d = tnego_pkg::PS_SBIAC;
          end else if (!sub_has_q) begin
            sub_first_d = rx_byte_i;
            sub_has_d   = 1'b1;
          end
        end
        tnego_pkg::PS_SBIAC: begin
          if (rx_byte_i == tnego_pkg::B_SE) begin
            state_d = tnego_pkg::PS_DATA;
            if (sub_has_q && (sub_first_q == tnego_pkg::SUB_SEND)) begin
              if (sub_option_q == tnego_pkg::OPT_TTYPE) begin
                desc_o.first = tnego_pkg::SEG_TTYPE;
              end else if ((sub_option_q == tnego_pkg::OPT_ENV) ||
                           (sub_option_q == tnego_pkg::OPT_NEWENV)) begin
                desc_o.first = tnego_pkg::SEG_ENV;
                desc_o.opt   = sub_option_q;
              end
            end
          end else begin
            state_d = tnego_pkg::PS_SBDATA;
            if ((rx_byte_i == tnego_pkg::B_IAC) && !sub_has_q) begin
              sub_first_d = rx_byte_i;
              sub_has_d   = 1'b1;
            end
          end
        end
        default: begin
          state_d = tnego_pkg::PS_DATA;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= tnego_pkg::PS_DATA;
      held_verb_q  <= 8'd0;
      sub_option_q <= 8'd0;
      sub_first_q  <= 8'd0;
      sub_has_q    <= 1'b0;
      caps_q       <= 1'b0;
    end else if (accept_i) begin
      state_q      <= state_d;
      held_verb_q  <= held_verb_d;
      sub_option_q <= sub_option_d;
      sub_first_q  <= sub_first_d;
      sub_has_q    <= sub_has_d;
      caps_q       <= caps_d;
    end
  end

  assign state_o = state_q;

endmodule

`default_nettype wire

[rtl/tnego_emitter.sv]
// reply sequencer: walks burst segments and drives the result register
`default_nettype none

module tnego_emitter (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             load_i,
  input  tnego_pkg::desc_t      desc_i,
  output logic                  free_o,
  output logic                  out_valid_o,
  input  wire logic             out_ready_i,
  output logic                  channel_o,
  output logic [7:0]            out_byte_o,
  output logic                  last_o
);

  logic           busy_q, busy_d;
  tnego_pkg::seg_e seg_q, seg_d;
  tnego_pkg::seg_e tail_q, tail_d;
  logic [7:0]     verb_q, verb_d;
  logic [7:0]     opt_q, opt_d;
  logic [5:0]     idx_q, idx_d;

  logic       valid_q;
  logic       chan_q;
  logic [7:0] byte_q;
  logic       last_q;

  logic adv, seg_last, burst_end;

  // step when the result register is empty or being drained
  assign adv       = busy_q && (!valid_q || out_ready_i);
  assign seg_last  = (idx_q == (tnego_pkg::seg_len(seg_q) - 6'd1));
  assign burst_end = seg_last && (seg_q != tnego_pkg::SEG_CAPS) &&
                     !((seg_q == tnego_pkg::SEG_CMD) && (tail_q != tnego_pkg::SEG_NONE));
  assign free_o    = !busy_q || (adv && burst_end);

  always_comb begin
    busy_d = busy_q;
    seg_d  = seg_q;
    tail_d = tail_q;
    verb_d = verb_q;
    opt_d  = opt_q;
    idx_d  = idx_q;
    if (load_i && (desc_i.first != tnego_pkg::SEG_NONE)) begin
      busy_d = 1'b1;
      seg_d  = desc_i.first;
      tail_d = desc_i.tail;
      verb_d = desc_i.verb;
      opt_d  = desc_i.opt;
      idx_d  = 6'd0;
    end else if (adv) begin
      if (!seg_last) begin
        idx_d = idx_q + 6'd1;
      end else if (burst_end) begin
        busy_d = 1'b0;
      end else begin
        // caps offer is always followed by the command answer
        seg_d = (seg_q == tnego_pkg::SEG_CAPS) ? tnego_pkg::SEG_CMD : tail_q;
        idx_d = 6'd0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q  <= 1'b0;
      seg_q   <= tnego_pkg::SEG_NONE;
      tail_q  <= tnego_pkg::SEG_NONE;
      idx_q   <= 6'd0;
      valid_q <= 1'b0;
    end else begin
      busy_q <= busy_d;
      seg_q  <= seg_d;
      tail_q <= tail_d;
      idx_q  <= idx_d;
      if (adv) begin
        valid_q <= 1'b1;
      end else if (out_ready_i) begin
        valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    verb_q <= verb_d;
    opt_q  <= opt_d;
    if (adv) begin
      chan_q <= (seg_q != tnego_pkg::SEG_DATA);
      byte_q <= tnego_pkg::seg_byte(seg_q, idx_q, verb_q, opt_q);
      last_q <= burst_end;
    end
  end

  assign out_valid_o = valid_q;
  assign channel_o   = chan_q;
  assign out_byte_o  = byte_q;
  assign last_o      = last_q;

endmodule

`default_nettype wire

[rtl/telnet_option_negotiator.sv]
// top level of the telnet option negotiator
//
//   channel  | direction | signals                               | carries
//   ---------+-----------+---------------------------------------+----------------------------
//   input    | in        | in_valid_i, in_ready_o, rx_byte_i     | one received byte per item
//   output   | out       | out_valid_o, out_ready_i, channel_o,  | one emitted byte per item,
//            |           | out_byte_o, last_o                    | last marks end of burst
//
// a data byte passes through the sequencer registers and then the result register; data
// streams at one item per cycle while the output side keeps up
// a reply leaves one byte per cycle while the output side keeps up, and input stalls while
// the burst (3 to 52 bytes) plays out; a carriage return or a step with no reply never stalls
// reset puts the parser in the data state with no offers sent and empties the
// result register; no clearing pass
`default_nettype none
`include "assert_macros.svh"

module telnet_option_negotiator (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       in_valid_i,
  output logic            in_ready_o,
  input  wire logic [7:0] rx_byte_i,
  output logic            out_valid_o,
  input  wire logic       out_ready_i,
  output logic            channel_o,
  output logic [7:0]      out_byte_o,
  output logic            last_o
);

  tnego_pkg::desc_t desc;
  tnego_pkg::ps_e   parse_state;
  logic             accept;
  logic             free;

  // input is taken whenever the sequencer is idle or finishing its burst
  assign in_ready_o = free;
  assign accept     = in_valid_i && free;

  // parser: decodes one byte against the held state, yields a reply descriptor
  tnego_parser u_parser (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .accept_i  (accept),
    .rx_byte_i (rx_byte_i),
    .desc_o    (desc),
    .state_o   (parse_state)
  );

  // emitter: plays the descriptor out one byte per cycle into the result register while it is drained
  tnego_emitter u_emitter (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (accept),
    .desc_i      (desc),
    .free_o      (free),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .channel_o   (channel_o),
    .out_byte_o  (out_byte_o),
    .last_o      (last_o)
  );

  // terminal bytes are always single-item results
  `TNEGO_ASSERT_SAME(a_data_last, clk_i, rst_ni, out_valid_o && !channel_o, last_o, "data byte without last")

  // carriage return never reaches the terminal
  `TNEGO_ASSERT_SAME(a_no_cr, clk_i, rst_ni, out_valid_o && !channel_o, out_byte_o != tnego_pkg::B_CR, "carriage return passed")

  // carriage return leaves the parser untouched
  `TNEGO_ASSERT_NEXT(a_cr_hold, clk_i, rst_ni, accept && (rx_byte_i == tnego_pkg::B_CR), $stable(parse_state), "parser moved on carriage return")

endmodule

`default_nettype wire
